@@ design/fsn_pkg.sv @@
// Shared types, constants and helpers for the fit-scale nearest address generator.
package fsn_pkg;

  // Field and datapath widths.
  localparam int DIM_W      = 13;
  localparam int POS_W      = 12;
  localparam int BPP_W      = 3;
  localparam int OFF_W      = 26;
  localparam int PITCH_W    = 15;
  localparam int PROD_W     = 2 * DIM_W - 1;
  localparam int CNT_W      = 5;
  localparam int CFG_ADDR_W = 3;

  // Largest image or screen dimension honored.
  localparam int MAX_DIM = 4096;

  // Per-item divider: quotient bits resolved per pipeline stage.
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = POS_W / DIV_STEPS;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SCREEN_BPP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 3'd4;

  // Geometry sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP,
    ST_PROD,
    ST_SELECT,
    ST_DIVIDE,
    ST_FIT,
    ST_ORIGIN
  } setup_state_t;

  // Picture geometry derived from the configuration.
  typedef struct packed {
    logic [DIM_W-1:0]   dw;
    logic [DIM_W-1:0]   dh;
    logic [DIM_W-1:0]   w;
    logic [DIM_W-1:0]   h;
    logic [POS_W-1:0]   x0;
    logic [POS_W-1:0]   y0;
    logic [PITCH_W-1:0] pitch;
  } geom_t;

  // Partial state of one restoring division in the item pipeline.
  typedef struct packed {
    logic [POS_W-1:0] rem;
    logic [POS_W-1:0] num;
    logic [POS_W-1:0] quot;
  } div_t;

  // Force a dimension register into the range 1 to MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

@@ design/fsn_div_stage.sv @@
// One registered stage of the pipelined restoring divider.
module fsn_div_stage
  import fsn_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  div_t             din,
  input  logic [DIM_W-1:0] divisor,
  output div_t             dout
);

  logic [POS_W-1:0] rem;
  logic [POS_W-1:0] num;
  logic [POS_W-1:0] quot;
  logic [DIM_W-1:0] trial;
  div_t             nxt;

  // Resolve DIV_STEPS quotient bits: shift in a numerator bit, subtract if it fits.
  always_comb begin
    rem   = din.rem;
    num   = din.num;
    quot  = din.quot;
    trial = '0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {rem, num[POS_W-1]};
      num   = {num[POS_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem  = POS_W'(trial - divisor);
        quot = {quot[POS_W-2:0], 1'b1};
      end else begin
        rem  = trial[POS_W-1:0];
        quot = {quot[POS_W-2:0], 1'b0};
      end
    end
    nxt = '{rem: rem, num: num, quot: quot};
  end

  // Stage register, held while the stage is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

@@ design/fsn_setup.sv @@
// Configuration registers and the sequencer that derives the picture geometry.
module fsn_setup
  import fsn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data,
  output geom_t                 geom,
  output logic                  busy
);

  logic [DIM_W-1:0] screen_width;
  logic [DIM_W-1:0] screen_height;
  logic [BPP_W-1:0] screen_bpp;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  setup_state_t state;
  setup_state_t state_next;

  logic [DIM_W-1:0]  sw;
  logic [DIM_W-1:0]  sh;
  logic [DIM_W-1:0]  w;
  logic [DIM_W-1:0]  h;
  logic [BPP_W-1:0]  bpp;
  logic              shrink;
  logic              by_height;
  logic [PROD_W-1:0] prod_ws;
  logic [PROD_W-1:0] prod_sh;
  logic [PROD_W-1:0] num;
  logic [DIM_W-1:0]  divisor;
  logic [POS_W-1:0]  rem;
  logic [DIM_W-1:0]  quot;
  logic [DIM_W-1:0]  quot_fit;
  logic [CNT_W-1:0]  cnt;
  logic [DIM_W-1:0]  trial;

  // Register file; only indexes in the list are stored.
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DIM_W'(800);
      screen_height <= DIM_W'(480);
      screen_bpp    <= BPP_W'(4);
      image_width   <= DIM_W'(800);
      image_height  <= DIM_W'(480);
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        REG_SCREEN_BPP:    screen_bpp    <= cfg_data[BPP_W-1:0];
        REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state register; reset starts a geometry pass.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLAMP;
    end else begin
      state <= state_next;
    end
  end

  // Next state; any write restarts the pass.
  always_comb begin
    state_next = state;
    busy       = (state != ST_IDLE);
    if (cfg_wr) begin
      state_next = ST_CLAMP;
    end else begin
      unique case (state)
        ST_IDLE:   state_next = ST_IDLE;
        ST_CLAMP:  state_next = ST_PROD;
        ST_PROD:   state_next = ST_SELECT;
        ST_SELECT: state_next = shrink ? ST_DIVIDE : ST_FIT;
        ST_DIVIDE: state_next = (cnt == CNT_W'(PROD_W - 1)) ? ST_FIT : ST_DIVIDE;
        ST_FIT:    state_next = ST_ORIGIN;
        ST_ORIGIN: state_next = ST_IDLE;
        default:   state_next = ST_CLAMP;
      endcase
    end
  end

  assign trial    = {rem, num[PROD_W-1]};
  assign quot_fit = (quot == '0) ? DIM_W'(1) : quot;

  // Geometry datapath: clamp, cross products, one quotient bit a cycle, origin.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_CLAMP: begin
        sw <= clamp_dim(screen_width);
        sh <= clamp_dim(screen_height);
        w  <= clamp_dim(image_width);
        h  <= clamp_dim(image_height);
        if (screen_bpp == '0) begin
          bpp <= BPP_W'(1);
        end else if (screen_bpp > BPP_W'(4)) begin
          bpp <= BPP_W'(4);
        end else begin
          bpp <= screen_bpp;
        end
      end
      ST_PROD: begin
        prod_ws <= PROD_W'(w * sh);
        prod_sh <= PROD_W'(sw * h);
        shrink  <= (w > sw) || (h > sh);
      end
      ST_SELECT: begin
        cnt  <= '0;
        rem  <= '0;
        quot <= '0;
        if (prod_ws < prod_sh) begin
          by_height <= 1'b1;
          num       <= prod_ws;
          divisor   <= h;
        end else begin
          by_height <= 1'b0;
          num       <= prod_sh;
          divisor   <= w;
        end
      end
      ST_DIVIDE: begin
        num <= {num[PROD_W-2:0], 1'b0};
        cnt <= cnt + CNT_W'(1);
        if (trial >= divisor) begin
          rem  <= POS_W'(trial - divisor);
          quot <= {quot[DIM_W-2:0], 1'b1};
        end else begin
          rem  <= trial[POS_W-1:0];
          quot <= {quot[DIM_W-2:0], 1'b0};
        end
      end
      ST_FIT: begin
        if (!shrink) begin
          geom.dw <= w;
          geom.dh <= h;
        end else if (by_height) begin
          geom.dw <= quot_fit;
          geom.dh <= sh;
        end else begin
          geom.dw <= sw;
          geom.dh <= quot_fit;
        end
      end
      ST_ORIGIN: begin
        geom.w     <= w;
        geom.h     <= h;
        geom.x0    <= POS_W'((sw - geom.dw) >> 1);
        geom.y0    <= POS_W'((sh - geom.dh) >> 1);
        geom.pitch <= PITCH_W'(sw * bpp);
      end
      default: ;
    endcase
  end

  // A finished pass never leaves an empty or oversized picture.
  a_fit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (geom.dw != '0) && (geom.dh != '0) &&
      (geom.dw <= DIM_W'(MAX_DIM)) && (geom.dh <= DIM_W'(MAX_DIM)))
    else $error("derived picture size out of range");

  // A write always reopens the geometry pass.
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> busy)
    else $error("geometry not recalculated after a write");

  // The division never runs past the numerator width.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (cnt < CNT_W'(PROD_W)))
    else $error("divide counter overran");

endmodule

@@ design/fit_scale_nearest_address_gen_core.sv @@
// Top level: per-pixel address pipeline with handshake and geometry setup.
// Throughput: one item per cycle unless m_tready or a geometry pass stalls it;
// the pipeline is six two-bit divider stages between a multiply front end
// and a multiply-add back end, bubbles collapse.
// Reset (synchronous, rst high) clears all valid bits and loads the default registers;
// s_tready then stays low for the geometry pass, longer when the image is shrunk.
// A configuration write holds s_tready low in its own cycle and starts the same pass.
module fit_scale_nearest_address_gen_core
  import fsn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [DIM_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,  // pos_x[11:0], pos_y[23:12]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // src_col[11:0], src_row[23:12], src_offset[49:24], dst_offset[75:50],
  // drawn_width[88:76], drawn_height[101:89], zero[103:102]
  output logic [103:0]          m_tdata,
  output logic                  m_tuser   // in_picture[0]
);

  localparam int NUM_STAGES = DIV_STAGES + 4;
  localparam int DIV_FIRST  = 2;
  localparam int ST_MUL2    = DIV_FIRST + DIV_STAGES;
  localparam int ST_OUT     = NUM_STAGES - 1;

  geom_t geom;
  logic  busy;

  logic [NUM_STAGES-1:0] v;
  logic [NUM_STAGES-1:0] rdy;
  logic                  in_fire;

  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  // Stage 1: captured position, bounds check and origin sums.
  logic [POS_W-1:0] x1;
  logic [POS_W-1:0] y1;
  logic             inp1;
  logic [DIM_W-1:0] xs1;
  logic [DIM_W-1:0] ys1;

  // Stage 2: scaled numerators and the row part of the screen offset.
  logic [2*POS_W-1:0] nx2;
  logic [2*POS_W-1:0] ny2;
  logic [OFF_W-1:0]   dpart2;
  logic [DIM_W-1:0]   xs2;
  logic               inp2;

  // Divider stages and their side band.
  div_t             col_d [DIV_STAGES];
  div_t             row_d [DIV_STAGES];
  div_t             col_init;
  div_t             row_init;
  logic             inp_d [DIV_STAGES];
  logic [OFF_W-1:0] dst_d [DIV_STAGES];

  // Source row times width.
  logic [OFF_W-1:0] prod9;
  logic [POS_W-1:0] sc9;
  logic [POS_W-1:0] sr9;
  logic             inp9;
  logic [OFF_W-1:0] dst9;
  logic [OFF_W-1:0] sum9;

  // Output register.
  logic             inp_o;
  logic [POS_W-1:0] sc_o;
  logic [POS_W-1:0] sr_o;
  logic [OFF_W-1:0] src_o;
  logic [OFF_W-1:0] dst_o;

  fsn_setup u_setup (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .geom     (geom),
    .busy     (busy)
  );

  // A stage may load when it is empty or its successor takes its item.
  always_comb begin
    rdy[ST_OUT] = !v[ST_OUT] || m_tready;
    for (int i = ST_OUT - 1; i >= 0; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign s_tready = rdy[0] && !busy && !cfg_wr;
  assign in_fire  = s_tvalid && s_tready;
  assign pos_x    = s_tdata[POS_W-1:0];
  assign pos_y    = s_tdata[2*POS_W-1:POS_W];

  // Valid bits travel with the items.
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) begin
        v[0] <= in_fire;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Front end: bounds, origin sums, then the three products.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      x1   <= pos_x;
      y1   <= pos_y;
      inp1 <= ({1'b0, pos_x} < geom.dw) && ({1'b0, pos_y} < geom.dh);
      xs1  <= DIM_W'(geom.x0) + DIM_W'(pos_x);
      ys1  <= DIM_W'(geom.y0) + DIM_W'(pos_y);
    end
    if (rdy[1]) begin
      nx2    <= (2*POS_W)'(x1 * geom.w);
      ny2    <= (2*POS_W)'(y1 * geom.h);
      dpart2 <= OFF_W'(ys1 * geom.pitch);
      xs2    <= xs1;
      inp2   <= inp1;
    end
  end

  // Inside the picture, numerator < divisor * 2^12, so its top half starts the remainder.
  assign col_init = '{rem: nx2[2*POS_W-1:POS_W], num: nx2[POS_W-1:0], quot: '0};
  assign row_init = '{rem: ny2[2*POS_W-1:POS_W], num: ny2[POS_W-1:0], quot: '0};

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    fsn_div_stage u_col (
      .clk     (clk),
      .en      (rdy[DIV_FIRST+k]),
      .din     ((k == 0) ? col_init : col_d[(k == 0) ? 0 : k-1]),
      .divisor (geom.dw),
      .dout    (col_d[k])
    );
    fsn_div_stage u_row (
      .clk     (clk),
      .en      (rdy[DIV_FIRST+k]),
      .din     ((k == 0) ? row_init : row_d[(k == 0) ? 0 : k-1]),
      .divisor (geom.dh),
      .dout    (row_d[k])
    );
  end

  // Side band through the divider; the screen offset completes on entry.
  always_ff @(posedge clk) begin
    if (rdy[DIV_FIRST]) begin
      inp_d[0] <= inp2;
      dst_d[0] <= dpart2 + OFF_W'({xs2, 2'b00});
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (rdy[DIV_FIRST+k]) begin
        inp_d[k] <= inp_d[k-1];
        dst_d[k] <= dst_d[k-1];
      end
    end
  end

  assign sum9 = prod9 + OFF_W'(sc9);

  // Back end: row times width, then three bytes per source pixel.
  always_ff @(posedge clk) begin
    if (rdy[ST_MUL2]) begin
      prod9 <= OFF_W'(row_d[DIV_STAGES-1].quot * geom.w);
      sc9   <= col_d[DIV_STAGES-1].quot;
      sr9   <= row_d[DIV_STAGES-1].quot;
      inp9  <= inp_d[DIV_STAGES-1];
      dst9  <= dst_d[DIV_STAGES-1];
    end
    if (rdy[ST_OUT]) begin
      inp_o <= inp9;
      sc_o  <= inp9 ? sc9 : '0;
      sr_o  <= inp9 ? sr9 : '0;
      src_o <= inp9 ? (sum9 + {sum9[OFF_W-2:0], 1'b0}) : '0;
      dst_o <= inp9 ? dst9 : '0;
    end
  end

  assign m_tvalid = v[ST_OUT];
  assign m_tuser  = inp_o;
  assign m_tdata  = {2'b00, geom.dh, geom.dw, dst_o, src_o, sr_o, sc_o};

  // A position outside the picture carries no addresses.
  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[75:0] == '0))
    else $error("outside item carries nonzero addresses");

  // Right after reset no item is taken, since the geometry pass then runs.
  a_reset_hold: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_tready)
    else $error("input ready during geometry pass after reset");

  // Reset leaves no result behind.
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

endmodule
